// File: rtl/qmtb_pkg.sv
`timescale 1ns / 1ps

package qmtb_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 27;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_MOVE = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } st_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture op and key of a new transfer
        logic rd_first;    // read the head entry, rewind the walk pointer
        logic rd_next;     // read the entry after the pointer, advance the pointer
        logic wr_enq;      // write key at the tail
        logic wr_shift;    // pull the arriving entry one place toward the head
        logic wr_last;     // write key into the last occupied slot
        logic enq_commit;  // grow the queue by one
        logic deq_commit;  // drop the head entry
        logic res_we;      // load the result registers
        logic res_take_rd; // result value is the entry just read
        st_t  res_status;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic hit;     // arriving entry equals the key
        logic last;    // arriving entry is the last occupied one
        logic at_end;  // pointer has walked past the last occupied entry
    } dp_stat_t;

    // Physical slot of the entry at offset off from head, wrapped into 0..DEPTH-1
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W:0] off);
        logic [CNT_W+1:0] s;
        s = (CNT_W + 2)'(head) + (CNT_W + 2)'(off);
        if (s >= (CNT_W + 2)'(DEPTH))
            s = s - (CNT_W + 2)'(DEPTH);
        if (s >= (CNT_W + 2)'(DEPTH))
            s = s - (CNT_W + 2)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/qmtb_ram.sv
`timescale 1ns / 1ps

module qmtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/qmtb_dp.sv
`timescale 1ns / 1ps

module qmtb_dp
    import qmtb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] key,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic [KEY_W-1:0] read_value,
    output logic [1:0]       status,
    output logic [OCC_W-1:0] occupancy
);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg;
    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] rv_reg;
    st_t              st_reg;

    logic [CNT_W:0]   rd_off;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             we;
    logic [KEY_W-1:0] rdata;

    assign rd_off = cmd.rd_next ? ({1'b0, ptr_reg} + (CNT_W + 1)'(1)) : '0;
    assign raddr  = slot_of(head_reg, rd_off);
    assign we     = cmd.wr_enq | cmd.wr_shift | cmd.wr_last;

    always_comb
    begin
        priority if (cmd.wr_shift)
        begin
            waddr = slot_of(head_reg, {1'b0, ptr_reg} - (CNT_W + 1)'(1));
            wdata = rdata;
        end
        else if (cmd.wr_last)
        begin
            waddr = slot_of(head_reg, {1'b0, count_reg} - (CNT_W + 1)'(1));
            wdata = key_reg;
        end
        else
        begin
            waddr = slot_of(head_reg, {1'b0, count_reg});
            wdata = key_reg;
        end
    end

    qmtb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.enq_commit)
            count_next = count_reg + CNT_W'(1);
        if (cmd.deq_commit)
        begin
            head_next  = slot_of(head_reg, (CNT_W + 1)'(1));
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(op);
            key_reg <= key;
        end
        if (cmd.rd_first)
            ptr_reg <= '0;
        else if (cmd.rd_next)
            ptr_reg <= ptr_reg + CNT_W'(1);
        if (cmd.res_we)
        begin
            rv_reg <= cmd.res_take_rd ? rdata : '0;
            st_reg <= cmd.res_status;
        end
    end

    assign stat.op     = op_reg;
    assign stat.full   = (count_reg == CNT_W'(DEPTH));
    assign stat.empty  = (count_reg == '0);
    assign stat.hit    = (rdata == key_reg);
    assign stat.last   = (({1'b0, ptr_reg} + (CNT_W + 1)'(1)) == {1'b0, count_reg});
    assign stat.at_end = (ptr_reg == count_reg);

    assign read_value = rv_reg;
    assign status     = st_reg;
    assign occupancy  = OCC_W'(count_reg);

endmodule

// File: rtl/qmtb_ctrl.sv
`timescale 1ns / 1ps

module qmtb_ctrl
    import qmtb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEQ,
        S_SEARCH,
        S_SHIFT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   fin;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        fin        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_ENQ:
                    begin
                        fin = 1'b1;
                        if (stat.full)
                            cmd.res_status = ST_FULL;
                        else
                        begin
                            cmd.wr_enq     = 1'b1;
                            cmd.enq_commit = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            fin            = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_DEQ;
                        end
                    end
                    OP_MOVE:
                    begin
                        if (stat.empty)
                        begin
                            fin            = 1'b1;
                            cmd.res_status = ST_MISS;
                        end
                        else
                        begin
                            cmd.rd_first = 1'b1;
                            state_next   = S_SEARCH;
                        end
                    end
                    OP_NOP:
                    begin
                        fin            = 1'b1;
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_DEQ:
            begin
                fin             = 1'b1;
                cmd.res_take_rd = 1'b1;
                cmd.deq_commit  = 1'b1;
                cmd.res_status  = ST_OK;
            end
            S_SEARCH:
            begin
                priority if (stat.hit)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT;
                end
                else if (stat.last)
                begin
                    fin            = 1'b1;
                    cmd.res_status = ST_MISS;
                end
                else
                    cmd.rd_next = 1'b1;
            end
            S_SHIFT:
            begin
                if (stat.at_end)
                begin
                    fin            = 1'b1;
                    cmd.wr_last    = 1'b1;
                    cmd.res_status = ST_OK;
                end
                else
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.rd_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            cmd.res_we = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= fin;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: rtl/queue_move_key_to_back_core.sv
`timescale 1ns / 1ps

// Bounded FIFO of 27-bit keys (DEPTH entries, 16 here) with enqueue, dequeue
// and move-to-back. A command transfers at the rising edge where start is
// high and busy is low; exactly one result follows, shown for a single cycle
// with done high, and the receiver must take it then: there is no way to stall
// the result. A move reads the entries from the head until one equals the key,
// pulls each later entry one place toward the head and writes the key into the
// last occupied slot; a miss walks the whole queue and reports ST_MISS.
// The walk over the circular store reads one entry per cycle through the single
// registered read port of the entry RAM. busy falls in the same cycle that done
// rises, so the next command may transfer while the result is on the ports. The
// entry store has no reset; only data read from occupied slots is used.

module queue_move_key_to_back_core
    import qmtb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       op,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [KEY_W-1:0] read_value,
    output logic [1:0]       status,
    output logic [OCC_W-1:0] occupancy
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each transfer: decode, walk, shift, report
    qmtb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold head, count, walk pointer, entry RAM and result registers
    qmtb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .key        (key),
        .cmd        (cmd),
        .stat       (stat),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule
